[rtl/core/tch_pkg.sv]
package tch_pkg;

	localparam int MAX_SLOTS  = 1024;
	localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
	localparam int SIZE_BITS  = SLOT_BITS + 1;
	localparam int KEY_BITS   = 37;
	localparam int VALUE_BITS = 32;
	localparam int CNT_BITS   = $clog2(KEY_BITS);

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(10);
	localparam logic [SIZE_BITS-1:0] SIZE_MIN   = SIZE_BITS'(3);
	localparam logic [SIZE_BITS-1:0] SIZE_MAX   = SIZE_BITS'(MAX_SLOTS);
	localparam logic [SIZE_BITS-1:0] PROBE_GAP  = SIZE_BITS'(2);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef enum logic [1:0] {
		TAG_EMPTY   = 2'd0,
		TAG_USED    = 2'd1,
		TAG_DELETED = 2'd2
	} tag_t;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_MOD    = 6'b000100,
		S_PROBE1 = 6'b001000,
		S_PROBE2 = 6'b010000,
		S_DECIDE = 6'b100000
	} state_t;

	// Control of the serial remainder unit.
	typedef struct packed {
		logic clear;
		logic step;
		logic din;
	} mod_ctl_t;

endpackage

[rtl/core/tch_mod_serial.sv]
module tch_mod_serial
	import tch_pkg::*;
(
	input  logic                 clk,
	input  mod_ctl_t             ctl,
	input  logic [SIZE_BITS-1:0] mod_a,
	input  logic [SIZE_BITS-1:0] mod_b,
	output logic [SLOT_BITS-1:0] rem_a,
	output logic [SLOT_BITS-1:0] rem_b
);

	logic [SLOT_BITS-1:0] rem_a_q, rem_b_q;
	logic [SIZE_BITS-1:0] t_a, t_b, n_a, n_b;

	// Restoring reduction, one key bit per cycle while step is high, from the top:
	// the partial remainder is doubled, the new bit shifted in, and the modulus
	// taken off once when it fits.
	always_comb begin
		t_a = {rem_a_q, ctl.din};
		t_b = {rem_b_q, ctl.din};
		n_a = (t_a >= mod_a) ? (t_a - mod_a) : t_a;
		n_b = (t_b >= mod_b) ? (t_b - mod_b) : t_b;
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			rem_a_q <= '0;
			rem_b_q <= '0;
		end else if (ctl.step) begin
			rem_a_q <= n_a[SLOT_BITS-1:0];
			rem_b_q <= n_b[SLOT_BITS-1:0];
		end
	end

	assign rem_a = rem_a_q;
	assign rem_b = rem_b_q;

endmodule

[rtl/core/two_choice_hash_table_top.sv]
// Channel   | Signals                                       | Handshake
// ----------+-----------------------------------------------+----------------------------
// request   | op, key, value                                | start high while busy low
// result    | status, value_out, slot, entry_count          | done high for one cycle
// config    | cfg_data (table_size)                         | cfg_valid and cfg_ready
//
// A request passes bit-serial reduction of the key by both moduli, then the two slot
// reads in S_PROBE1 and S_PROBE2 and the decide state S_DECIDE, then returns to idle.
// The result appears in the cycle after the decide cycle, in which start is taken again.
// After reset a clearing pass marks all 1024 slots empty, one a cycle, with busy high.
// The receiver cannot stall: done is a single-cycle strobe. cfg_ready is always high.
module two_choice_hash_table_top
	import tch_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  done,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] value_out,
	output logic [SLOT_BITS-1:0]  slot,
	output logic [SIZE_BITS-1:0]  entry_count,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [SIZE_BITS-1:0]  cfg_data
);

	state_t                state_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic [SIZE_BITS-1:0]  s_eff, mod_b;
	logic [SLOT_BITS-1:0]  clr_q;
	logic [CNT_BITS-1:0]   bit_q;
	logic [1:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [SIZE_BITS-1:0]  count_q;
	mod_ctl_t              mod_ctl;
	logic [SLOT_BITS-1:0]  p1, p2;
	logic [SLOT_BITS-1:0]  p2_rem;
	logic [SIZE_BITS-1:0]  p2_wide;
	logic                  accept;

	tag_t                  tag_mem [MAX_SLOTS];
	logic [KEY_BITS-1:0]   key_mem [MAX_SLOTS];
	logic [VALUE_BITS-1:0] val_mem [MAX_SLOTS];
	logic [SLOT_BITS-1:0]  rd_addr;
	tag_t                  tag_rd;
	logic [KEY_BITS-1:0]   key_rd;
	logic [VALUE_BITS-1:0] val_rd;

	logic                  tag_we, kv_we;
	logic [SLOT_BITS-1:0]  wr_addr;
	tag_t                  tag_wdata;

	tag_t                  tag1_q;
	logic                  match1_q;
	logic [VALUE_BITS-1:0] val1_q;

	logic                  hit;
	logic [SLOT_BITS-1:0]  hit_slot;
	logic [1:0]            res_status;
	logic [VALUE_BITS-1:0] res_value;
	logic [SIZE_BITS-1:0]  next_count;

	logic                  done_q;
	logic [1:0]            status_q;
	logic [VALUE_BITS-1:0] value_out_q;
	logic [SLOT_BITS-1:0]  slot_q;

	assign accept    = (state_q == S_IDLE) && start;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		s_eff = size_q;
		if (size_q < SIZE_MIN) begin
			s_eff = SIZE_MIN;
		end else if (size_q > SIZE_MAX) begin
			s_eff = SIZE_MAX;
		end
		mod_b = s_eff - PROBE_GAP;
	end

	assign mod_ctl.clear = accept;
	assign mod_ctl.step  = (state_q == S_MOD);
	assign mod_ctl.din   = key_q[KEY_BITS-1];

	tch_mod_serial u_mod (
		.clk   (clk),
		.ctl   (mod_ctl),
		.mod_a (s_eff),
		.mod_b (mod_b),
		.rem_a (p1),
		.rem_b (p2_rem)
	);

	// The second probe lies in one to size minus two, so it fits a slot index.
	assign p2_wide = mod_b - {1'b0, p2_rem};
	assign p2      = p2_wide[SLOT_BITS-1:0];

	assign rd_addr = (state_q == S_PROBE2) ? p2 : p1;

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[wr_addr] <= tag_wdata;
		end
		if (kv_we) begin
			key_mem[wr_addr] <= key_q;
			val_mem[wr_addr] <= val_q;
		end
		tag_rd <= tag_mem[rd_addr];
		key_rd <= key_mem[rd_addr];
		val_rd <= val_mem[rd_addr];
	end

	// Probe choice once both slots have been read. The first probe's data was
	// kept in the previous cycle; the second probe's data is on the read port.
	always_comb begin
		hit        = 1'b0;
		hit_slot   = p1;
		res_status = STAT_MISS;
		res_value  = '0;
		case (op_q)
			OP_INSERT: begin
				if (tag1_q != TAG_USED) begin
					hit = 1'b1;
				end else if (tag_rd != TAG_USED) begin
					hit      = 1'b1;
					hit_slot = p2;
				end
				res_status = hit ? STAT_OK : STAT_FULL;
			end
			OP_LOOKUP, OP_DELETE: begin
				if (tag1_q == TAG_USED && match1_q) begin
					hit       = 1'b1;
					res_value = val1_q;
				end else if (tag_rd == TAG_USED && key_rd == key_q) begin
					hit       = 1'b1;
					hit_slot  = p2;
					res_value = val_rd;
				end
				res_status = hit ? STAT_OK : STAT_MISS;
				if (op_q != OP_LOOKUP || !hit) begin
					res_value = '0;
				end
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		tag_we     = 1'b0;
		kv_we      = 1'b0;
		wr_addr    = hit_slot;
		tag_wdata  = TAG_USED;
		next_count = count_q;
		case (state_q)
			S_CLEAR: begin
				tag_we    = 1'b1;
				wr_addr   = clr_q;
				tag_wdata = TAG_EMPTY;
			end
			S_DECIDE: begin
				if (hit && op_q == OP_INSERT) begin
					tag_we     = 1'b1;
					kv_we      = 1'b1;
					next_count = count_q + 1'b1;
				end else if (hit && op_q == OP_DELETE) begin
					tag_we    = 1'b1;
					tag_wdata = TAG_DELETED;
					if (count_q != '0) begin
						next_count = count_q - 1'b1;
					end
				end
			end
			default: begin
				tag_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			bit_q   <= '0;
			size_q  <= SIZE_RESET;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_BITS'(MAX_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						bit_q   <= CNT_BITS'(KEY_BITS - 1);
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= S_PROBE1;
					end
				end
				S_PROBE1: begin
					state_q <= S_PROBE2;
				end
				S_PROBE2: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					count_q <= next_count;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload. The key rotates once round during the reduction, so it
	// is back in place for the compare and the write.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			key_q <= key;
			val_q <= value;
		end else if (state_q == S_MOD) begin
			key_q <= {key_q[KEY_BITS-2:0], key_q[KEY_BITS-1]};
		end
		if (state_q == S_PROBE2) begin
			tag1_q   <= tag_rd;
			match1_q <= (key_rd == key_q);
			val1_q   <= val_rd;
		end
		if (state_q == S_DECIDE) begin
			status_q    <= res_status;
			value_out_q <= res_value;
			slot_q      <= hit ? hit_slot : '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign value_out   = value_out_q;
	assign slot        = slot_q;
	assign entry_count = count_q;

	a_decide_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |=> done)
		else $error("decide cycle not followed by a result");

	a_count_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(entry_count))
		else $error("entry count changed without a result");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (slot == '0 && value_out == '0))
		else $error("unsuccessful request reported a slot or value");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> $stable(entry_count))
		else $error("full insert changed the entry count");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import tch_pkg::*;

	localparam logic [1:0] OP_SPARE      = 2'd3;
	localparam int         NUM_PHASES    = 10;
	localparam int         PHASE_ITEMS   = 150;
	localparam int         NO_IDLE_PHASE = 2;
	localparam int         IDLE_PERCENT  = 11;
	localparam int         POOL_DEPTH    = 48;
	localparam int         REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [1:0]            status;
		logic [VALUE_BITS-1:0] value_out;
		logic [SLOT_BITS-1:0]  slot;
		logic [SIZE_BITS-1:0]  entry_count;
	} reply_t;

	typedef struct {
		logic [1:0]            op;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		bit                    typed;
		reply_t                want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            req_op = OP_INSERT;
	logic [KEY_BITS-1:0]   req_key = '0;
	logic [VALUE_BITS-1:0] req_value = '0;
	logic                  done;
	logic [1:0]            status;
	logic [VALUE_BITS-1:0] value_out;
	logic [SLOT_BITS-1:0]  slot;
	logic [SIZE_BITS-1:0]  entry_count;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [SIZE_BITS-1:0]  cfg_data = '0;

	// Shadow copy of the slot store and the size register.
	tag_t                  tag_mem [MAX_SLOTS];
	logic [KEY_BITS-1:0]   key_mem [MAX_SLOTS];
	logic [VALUE_BITS-1:0] val_mem [MAX_SLOTS];
	int unsigned           held_count = 0;
	logic [SIZE_BITS-1:0]  size_reg = SIZE_RESET;

	reply_t                pending_replies[$];
	stim_row_t             directed_rows[$];
	logic [KEY_BITS-1:0]   key_pool[$];
	int unsigned           fault_count = 0;

	two_choice_hash_table_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (req_op),
		.key         (req_key),
		.value       (req_value),
		.done        (done),
		.status      (status),
		.value_out   (value_out),
		.slot        (slot),
		.entry_count (entry_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (tag_mem[i]) begin
			tag_mem[i] = TAG_EMPTY;
			key_mem[i] = '0;
			val_mem[i] = '0;
		end
	end

	function automatic int unsigned clamped_size(input logic [SIZE_BITS-1:0] s);
		int unsigned n;
		n = s;
		if (n < SIZE_MIN)
			n = SIZE_MIN;
		if (n > SIZE_MAX)
			n = SIZE_MAX;
		return n;
	endfunction

	// Applies one request to the shadow store and returns the reply it should give.
	function automatic reply_t table_apply(input logic [1:0] o, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		reply_t            r;
		int unsigned       s;
		int unsigned       p1;
		int unsigned       p2;
		int unsigned       hit;
		bit                found;
		longint unsigned   kk;
		kk = 64'(k);
		s = clamped_size(size_reg);
		p1 = int'(kk % s);
		p2 = s - PROBE_GAP - int'(kk % (s - PROBE_GAP));
		r = '0;
		r.status = STAT_MISS;
		hit = 0;
		found = 1'b0;
		case (o)
			OP_INSERT: begin
				if (tag_mem[p1] != TAG_USED) begin
					hit = p1;
					found = 1'b1;
				end else if (tag_mem[p2] != TAG_USED) begin
					hit = p2;
					found = 1'b1;
				end
				if (found) begin
					tag_mem[hit] = TAG_USED;
					key_mem[hit] = k;
					val_mem[hit] = v;
					held_count++;
					r.status = STAT_OK;
					r.slot = SLOT_BITS'(hit);
				end else begin
					r.status = STAT_FULL;
				end
			end
			OP_LOOKUP, OP_DELETE: begin
				if (tag_mem[p1] == TAG_USED && key_mem[p1] == k) begin
					hit = p1;
					found = 1'b1;
				end else if (tag_mem[p2] == TAG_USED && key_mem[p2] == k) begin
					hit = p2;
					found = 1'b1;
				end
				if (found) begin
					r.status = STAT_OK;
					r.slot = SLOT_BITS'(hit);
					if (o == OP_LOOKUP) begin
						r.value_out = val_mem[hit];
					end else begin
						tag_mem[hit] = TAG_DELETED;
						if (held_count > 0)
							held_count--;
					end
				end
			end
			default: ;
		endcase
		r.entry_count = SIZE_BITS'(held_count);
		return r;
	endfunction

	// Results are taken at the rising edge that ends their strobe cycle.
	always @(posedge clk) begin
		reply_t want;
		if (done === 1'b1) begin
			if (pending_replies.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected result: status %0d value %h slot %0d count %0d",
						status, value_out, slot, entry_count);
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status || value_out !== want.value_out ||
						slot !== want.slot || entry_count !== want.entry_count) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display({"mismatch at %0t: expected %0d %h %0d %0d,",
							" got %0d %h %0d %0d (status value slot count)"},
							$realtime, want.status, want.value_out, want.slot,
							want.entry_count, status, value_out, slot, entry_count);
				end
			end
		end
	end

	task automatic add_row(input logic [1:0] o, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v, input bit typed, input logic [1:0] st,
			input logic [VALUE_BITS-1:0] vo, input int unsigned sl, input int unsigned cnt);
		stim_row_t row;
		row.op = o;
		row.key = k;
		row.value = v;
		row.typed = typed;
		row.want.status = st;
		row.want.value_out = vo;
		row.want.slot = SLOT_BITS'(sl);
		row.want.entry_count = SIZE_BITS'(cnt);
		directed_rows.push_back(row);
	endtask

	// The pause starts once the block is ready, so that it really holds off a request.
	task automatic hold_off(input int unsigned cycles);
		@(negedge clk);
		start = 1'b0;
		while (busy) @(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	// Presents one request and returns once it has been taken.
	task automatic send_request(input logic [1:0] o, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v, input bit typed, input reply_t typed_want,
			input bit idle_on);
		reply_t predicted;
		if (idle_on && $urandom_range(99) < IDLE_PERCENT)
			hold_off($urandom_range(1, 80));
		predicted = table_apply(o, k, v);
		if (o == OP_INSERT && predicted.status == STAT_OK) begin
			key_pool.push_back(k);
			if (key_pool.size() > POOL_DEPTH)
				void'(key_pool.pop_front());
		end
		pending_replies.push_back(typed ? typed_want : predicted);
		@(negedge clk);
		start = 1'b1;
		req_op = o;
		req_key = k;
		req_value = v;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_BITS-1:0] s);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = s;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		size_reg = s;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly keys already held, or keys that hash onto the same two slots.
	function automatic logic [KEY_BITS-1:0] pick_key;
		int unsigned     r;
		int unsigned     s;
		longint unsigned kk;
		r = $urandom_range(99);
		s = clamped_size(size_reg);
		if (key_pool.size() != 0 && r < 55) begin
			kk = 64'(key_pool[$urandom_range(key_pool.size() - 1)]);
		end else if (key_pool.size() != 0 && r < 70) begin
			kk = 64'(key_pool[$urandom_range(key_pool.size() - 1)]) +
				64'(s) * 64'(s - PROBE_GAP) * 64'($urandom_range(1, 3));
		end else if (r < 80) begin
			kk = 64'($urandom_range(63));
		end else begin
			kk = {32'($urandom), 32'($urandom)};
		end
		return kk[KEY_BITS-1:0];
	endfunction

	initial begin
		int unsigned          phase_sizes[NUM_PHASES];
		logic [SIZE_BITS-1:0] s;
		logic [1:0]           o;
		int unsigned          r;
		reply_t               no_want;
		phase_sizes = '{3, 0, 1024, 2, 40, 1025, 1, 2047, 16, 0};
		no_want = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Table size left at its reset value of ten; second probe is 8 - key mod 8.
		add_row(OP_LOOKUP, 37'd0, 32'd0, 1, STAT_MISS, 32'd0, 0, 0);
		add_row(OP_DELETE, 37'd5, 32'd0, 1, STAT_MISS, 32'd0, 0, 0);
		add_row(OP_INSERT, 37'd0, 32'hFFFF_FFFF, 1, STAT_OK, 32'd0, 0, 1);
		add_row(OP_LOOKUP, 37'd0, 32'd0, 1, STAT_OK, 32'hFFFF_FFFF, 0, 1);
		add_row(OP_INSERT, 37'h1F_FFFF_FFFF, 32'd0, 1, STAT_OK, 32'd0, 1, 2);
		add_row(OP_LOOKUP, 37'h1F_FFFF_FFFF, 32'hFFFF_FFFF, 1, STAT_OK, 32'd0, 1, 2);
		add_row(OP_SPARE, 37'h1F_FFFF_FFFF, 32'hFFFF_FFFF, 1, STAT_MISS, 32'd0, 0, 2);
		add_row(OP_INSERT, 37'd10, 32'h1234_5678, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_INSERT, 37'd20, 32'h0, 0, STAT_OK, 32'd0, 0, 0);
		// A second copy of a key that is already held.
		add_row(OP_INSERT, 37'd0, 32'hA5A5_A5A5, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_INSERT, 37'd30, 32'h8000_0001, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_INSERT, 37'd40, 32'h7FFF_FFFE, 0, STAT_OK, 32'd0, 0, 0);
		// Both probes land on the same slot, which is already used.
		add_row(OP_INSERT, 37'd44, 32'h1, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_DELETE, 37'd0, 32'hFFFF_FFFF, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_LOOKUP, 37'd0, 32'd0, 0, STAT_OK, 32'd0, 0, 0);
		// The tombstone left by the delete is reused.
		add_row(OP_INSERT, 37'd50, 32'h5555_5555, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_DELETE, 37'd20, 32'd0, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_INSERT, 37'd44, 32'h0AAA_AAAA, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_LOOKUP, 37'd44, 32'd0, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_DELETE, 37'd10, 32'd0, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_LOOKUP, 37'd10, 32'd0, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_DELETE, 37'd10, 32'd0, 0, STAT_OK, 32'd0, 0, 0);
		// Same first probe as the largest key but a different key.
		add_row(OP_LOOKUP, 37'h1F_FFFF_FFF5, 32'd0, 0, STAT_OK, 32'd0, 0, 0);
		add_row(OP_LOOKUP, 37'd20, 32'd0, 0, STAT_OK, 32'd0, 0, 0);

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].want, 1'b1);

		// The store is kept across size changes, so every phase sees what the last left.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == NUM_PHASES - 1)
				s = SIZE_BITS'($urandom_range(5, MAX_SLOTS));
			else
				s = SIZE_BITS'(phase_sizes[phase]);
			write_size(s);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < 40)
					o = OP_INSERT;
				else if (r < 70)
					o = OP_LOOKUP;
				else if (r < 95)
					o = OP_DELETE;
				else
					o = OP_SPARE;
				send_request(o, pick_key(), $urandom, 1'b0, no_want, phase != NO_IDLE_PHASE);
			end
		end

		drain();
		repeat (60) @(posedge clk);
		if (fault_count == 0 && pending_replies.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
